### src/rna_pkg.sv
// Package: op codes, sequencer states and shared constants for the rational ALU.
`timescale 1ns / 1ps
`default_nettype none
package rna_pkg;

  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned PortWidth = 32;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_NEG    = 4'd4,
    OP_RECIP  = 4'd5,
    OP_REDUCE = 4'd6,
    OP_WHOLE  = 4'd7,
    OP_EQ     = 4'd8,
    OP_LT     = 4'd9,
    OP_LE     = 4'd10,
    OP_GT     = 4'd11,
    OP_GE     = 4'd12,
    OP_NE     = 4'd13
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ADDN,
    ST_GCD_A,
    ST_GCD_AW,
    ST_DIVN_A,
    ST_DIVN_AW,
    ST_DIVD_A,
    ST_DIVD_AW,
    ST_GCD_B,
    ST_GCD_BW,
    ST_DIVN_B,
    ST_DIVN_BW,
    ST_DIVD_B,
    ST_DIVD_BW,
    ST_CMP,
    ST_WHOLE,
    ST_WHOLE_W,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

### src/rna_if.sv
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface rna_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/rna_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rna_divider #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W-1:0]  quot_q, quot_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [W:0]    trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dsr_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in next dividend bit; keep if subtract does not borrow
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### src/rna_core.sv
// Sequencer: multiplier steps, Euclid gcd and reductions through the shared divider.
`timescale 1ns / 1ps
`default_nettype none
module rna_core #(
  parameter int unsigned DATA_WIDTH = rna_pkg::DataWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 hold_i,
  input  wire logic [3:0]           op_i,
  input  wire logic [DATA_WIDTH-1:0] an_i,
  input  wire logic [DATA_WIDTH-1:0] ad_i,
  input  wire logic [DATA_WIDTH-1:0] bn_i,
  input  wire logic [DATA_WIDTH-1:0] bd_i,
  output logic                      idle_o,
  output logic                      done_o,
  output logic [DATA_WIDTH-1:0]     rn_o,
  output logic [DATA_WIDTH-1:0]     rd_o,
  output logic                      cmp_o,
  output logic                      err_o
);
  localparam int unsigned W = DATA_WIDTH;

  rna_pkg::state_e state_q, state_d;
  logic [3:0]   op_q, op_d;
  logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] xn_q, xn_d, xd_q, xd_d, yn_q, yn_d, yd_q, yd_d;
  logic [W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [2*W-1:0] p1_q, p1_d, p2_q, p2_d;
  logic [W-1:0] rn_q, rn_d, rd_q, rd_d;
  logic         cmp_q, cmp_d, err_q, err_d;

  // shared multiplier
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared divider
  logic         div_start, div_done;
  logic [W-1:0] div_n, div_d, div_q, div_r;

  rna_divider #(.W(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  function automatic logic [W-1:0] absw(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  // signed value from unsigned magnitude and sign
  function automatic logic [W-1:0] sgn(input logic [W-1:0] m, input logic neg);
    return neg ? W'(-m) : m;
  endfunction

  logic eq, lt;
  assign eq = (xn_q == yn_q) && (xd_q == yd_q);
  assign lt = ($signed(p1_q) < $signed(p2_q)) && !eq;

  always_comb begin
    state_d = state_q;
    op_d = op_q; an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    xn_d = xn_q; xd_d = xd_q; yn_d = yn_q; yd_d = yd_q;
    gx_d = gx_q; gy_d = gy_q; p1_d = p1_q; p2_d = p2_q;
    rn_d = rn_q; rd_d = rd_q; cmp_d = cmp_q; err_d = err_q;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0;
    div_n = gx_q; div_d = gy_q;
    done_o = 1'b0;
    case (state_q)
      rna_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d = op_i; an_d = an_i; ad_d = ad_i; bd_d = bd_i;
          bn_d = (op_i == rna_pkg::OP_SUB) ? W'(-bn_i) : bn_i;
          rn_d = '0; rd_d = W'(1); cmp_d = 1'b0; err_d = 1'b0;
          xn_d = an_i; xd_d = ad_i; yn_d = bn_i; yd_d = bd_i;
          gx_d = absw(an_i); gy_d = absw(ad_i);
          case (op_i)
            rna_pkg::OP_ADD, rna_pkg::OP_SUB, rna_pkg::OP_MUL,
            rna_pkg::OP_DIV, rna_pkg::OP_EQ, rna_pkg::OP_LT,
            rna_pkg::OP_LE, rna_pkg::OP_GT, rna_pkg::OP_GE,
            rna_pkg::OP_NE: state_d = rna_pkg::ST_MUL1;
            rna_pkg::OP_NEG: begin
              rn_d = W'(-an_i); rd_d = ad_i; state_d = rna_pkg::ST_DONE;
            end
            rna_pkg::OP_RECIP: begin
              rn_d = ad_i; rd_d = an_i; err_d = (an_i == '0);
              state_d = rna_pkg::ST_DONE;
            end
            rna_pkg::OP_REDUCE: state_d = rna_pkg::ST_GCD_A;
            rna_pkg::OP_WHOLE: begin
              if (ad_i == '0) begin
                err_d = 1'b1; state_d = rna_pkg::ST_DONE;
              end else begin
                gx_d = absw(an_i); gy_d = absw(ad_i);
                state_d = rna_pkg::ST_WHOLE;
              end
            end
            default: state_d = rna_pkg::ST_DONE;
          endcase
        end
      end
      // first product: p1 depends on op
      rna_pkg::ST_MUL1: begin
        case (op_q)
          rna_pkg::OP_MUL: begin mul_a = an_q; mul_b = bn_q; end
          default: begin mul_a = an_q; mul_b = bd_q; end
        endcase
        p1_d = mul_p;
        state_d = rna_pkg::ST_MUL2;
      end
      rna_pkg::ST_MUL2: begin
        case (op_q)
          rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin mul_a = bn_q; mul_b = ad_q; end
          rna_pkg::OP_MUL: begin mul_a = ad_q; mul_b = bd_q; end
          rna_pkg::OP_DIV: begin mul_a = ad_q; mul_b = bn_q; end
          default: begin mul_a = bn_q; mul_b = ad_q; end
        endcase
        p2_d = mul_p;
        state_d = rna_pkg::ST_ADDN;
        if (op_q == rna_pkg::OP_MUL || op_q == rna_pkg::OP_DIV) begin
          rn_d = p1_q[W-1:0]; rd_d = mul_p[W-1:0];
          err_d = (op_q == rna_pkg::OP_DIV) && (bn_q == '0);
          state_d = rna_pkg::ST_DONE;
        end else if (op_q != rna_pkg::OP_ADD && op_q != rna_pkg::OP_SUB) begin
          gx_d = absw(xn_q); gy_d = absw(xd_q);
          state_d = rna_pkg::ST_GCD_A;
        end
      end
      rna_pkg::ST_ADDN: begin
        // cross-multiply the denominators for the unequal case
        mul_a = ad_q; mul_b = bd_q;
        if (ad_q == bd_q) begin
          rn_d = an_q + bn_q; rd_d = ad_q;
        end else begin
          rn_d = p1_q[W-1:0] + p2_q[W-1:0]; rd_d = mul_p[W-1:0];
        end
        state_d = rna_pkg::ST_DONE;
      end
      // Euclid on operand a or b: gx, gy start as |n|, |d|
      rna_pkg::ST_GCD_A, rna_pkg::ST_GCD_B: begin
        if (gy_q == '0) begin
          if (gx_q == '0) begin
            err_d = 1'b1;
            state_d = (state_q == rna_pkg::ST_GCD_A && op_q != rna_pkg::OP_REDUCE)
                      ? rna_pkg::ST_GCD_B : rna_pkg::ST_CMP;
            if (state_q == rna_pkg::ST_GCD_A) begin
              gx_d = absw(yn_q); gy_d = absw(yd_q);
            end
          end else begin
            state_d = (state_q == rna_pkg::ST_GCD_A) ? rna_pkg::ST_DIVN_A
                                                     : rna_pkg::ST_DIVN_B;
          end
        end else begin
          div_start = 1'b1;
          state_d = (state_q == rna_pkg::ST_GCD_A) ? rna_pkg::ST_GCD_AW
                                                   : rna_pkg::ST_GCD_BW;
        end
      end
      rna_pkg::ST_GCD_AW, rna_pkg::ST_GCD_BW: begin
        if (div_done) begin
          gx_d = gy_q; gy_d = div_r;
          state_d = (state_q == rna_pkg::ST_GCD_AW) ? rna_pkg::ST_GCD_A
                                                    : rna_pkg::ST_GCD_B;
        end
      end
      // divide numerator, then denominator, by gcd held in gx
      rna_pkg::ST_DIVN_A, rna_pkg::ST_DIVD_A, rna_pkg::ST_DIVN_B, rna_pkg::ST_DIVD_B: begin
        div_start = 1'b1;
        div_d = gx_q;
        case (state_q)
          rna_pkg::ST_DIVN_A: begin div_n = absw(xn_q); state_d = rna_pkg::ST_DIVN_AW; end
          rna_pkg::ST_DIVD_A: begin div_n = absw(xd_q); state_d = rna_pkg::ST_DIVD_AW; end
          rna_pkg::ST_DIVN_B: begin div_n = absw(yn_q); state_d = rna_pkg::ST_DIVN_BW; end
          default: begin div_n = absw(yd_q); state_d = rna_pkg::ST_DIVD_BW; end
        endcase
      end
      rna_pkg::ST_DIVN_AW: if (div_done) begin
        xn_d = sgn(div_q, xn_q[W-1]); state_d = rna_pkg::ST_DIVD_A;
      end
      rna_pkg::ST_DIVD_AW: if (div_done) begin
        xd_d = sgn(div_q, xd_q[W-1]);
        if (op_q == rna_pkg::OP_REDUCE) begin
          rn_d = xn_q; rd_d = sgn(div_q, xd_q[W-1]); state_d = rna_pkg::ST_DONE;
        end else begin
          gx_d = absw(yn_q); gy_d = absw(yd_q); state_d = rna_pkg::ST_GCD_B;
        end
      end
      rna_pkg::ST_DIVN_BW: if (div_done) begin
        yn_d = sgn(div_q, yn_q[W-1]); state_d = rna_pkg::ST_DIVD_B;
      end
      rna_pkg::ST_DIVD_BW: if (div_done) begin
        yd_d = sgn(div_q, yd_q[W-1]); state_d = rna_pkg::ST_CMP;
      end
      rna_pkg::ST_CMP: begin
        if (op_q == rna_pkg::OP_REDUCE) begin
          rn_d = xn_q; rd_d = xd_q;
        end else begin
          case (op_q)
            rna_pkg::OP_EQ: cmp_d = eq;
            rna_pkg::OP_LT: cmp_d = lt;
            rna_pkg::OP_LE: cmp_d = lt || eq;
            rna_pkg::OP_GT: cmp_d = !(lt || eq);
            rna_pkg::OP_GE: cmp_d = !lt || eq;
            default: cmp_d = !eq;
          endcase
        end
        state_d = rna_pkg::ST_DONE;
      end
      rna_pkg::ST_WHOLE: begin
        div_start = 1'b1;
        state_d = rna_pkg::ST_WHOLE_W;
      end
      rna_pkg::ST_WHOLE_W: if (div_done) begin
        rn_d = sgn(div_q, an_q[W-1] ^ ad_q[W-1]);
        state_d = rna_pkg::ST_DONE;
      end
      // result waits here while the output register is still occupied
      rna_pkg::ST_DONE: begin
        if (!hold_i) begin
          done_o = 1'b1;
          state_d = rna_pkg::ST_IDLE;
        end
      end
      default: state_d = rna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rna_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    xn_q <= xn_d; xd_q <= xd_d; yn_q <= yn_d; yd_q <= yd_d;
    gx_q <= gx_d; gy_q <= gy_d; p1_q <= p1_d; p2_q <= p2_d;
    rn_q <= rn_d; rd_q <= rd_d; cmp_q <= cmp_d; err_q <= err_d;
  end

  assign idle_o = (state_q == rna_pkg::ST_IDLE);
  assign rn_o = rn_q;
  assign rd_o = rd_q;
  assign cmp_o = cmp_q;
  assign err_o = err_q;
endmodule
`default_nettype wire

### src/rational_number_alu_top.sv
// Rational ALU top level: request channel, sequencer core, result register.
//
// Channels: req (op code and two fractions) and res (fraction, compare flag,
// error flag), both valid/ready; a transaction moves at valid && ready.
// One request is worked at a time; req_ready is high only while the core is
// idle, so a new request waits until the core has finished the last one.
// Work per op code, each division through the shared restoring divider:
//   neg, recip, whole part by zero, unused codes: set directly; mul, div: two products;
//   add, sub: two products, then the denominator product; whole part: one division;
//   reduce: Euclid, then numerator and denominator divided by the gcd;
//   comparisons: two products, then Euclid and two divisions per operand.
// Results land in an output register; while the receiver stalls, the result
// holds and a new request may already be taken and worked, its result held
// in the core until the output register frees.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module rational_number_alu_top #(
  parameter int unsigned DATA_WIDTH = rna_pkg::DataWidthDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rna_if.sink      req,
  rna_if.source    res
);
  localparam int unsigned PW = rna_pkg::PortWidth;

  logic idle, done, cmp, err, out_v_q;
  logic [DATA_WIDTH-1:0] rn, rd;

  assign req.ready = idle;

  rna_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(req.valid && req.ready),
    // core may finish only when the output register is free
    .hold_i (out_v_q && !res.ready),
    .op_i   (req.data.req_type),
    .an_i   (req.data.a_num[DATA_WIDTH-1:0]),
    .ad_i   (req.data.a_den[DATA_WIDTH-1:0]),
    .bn_i   (req.data.b_num[DATA_WIDTH-1:0]),
    .bd_i   (req.data.b_den[DATA_WIDTH-1:0]),
    .idle_o (idle),
    .done_o (done),
    .rn_o   (rn),
    .rd_o   (rd),
    .cmp_o  (cmp),
    .err_o  (err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      if (done) out_v_q <= 1'b1;
      else if (res.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res.data.res_num   <= PW'($signed(rn));
      res.data.res_den   <= PW'($signed(rd));
      res.data.cmp_true  <= cmp;
      res.data.div_error <= err;
    end
  end

  assign res.valid = out_v_q;

  // a result is only produced from a busy core
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> !idle)
    else $error("done while idle");
  // new result never overwrites a pending one
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> !out_v_q || res.ready)
    else $error("result overwritten");
  // every completion raises valid next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |=> out_v_q)
    else $error("lost result");
endmodule
`default_nettype wire

### test/rna_tb_pkg.sv
// Transaction payload types shared by the rational ALU testbench files.
`timescale 1ns / 1ps
package rna_tb_pkg;
  import rna_pkg::*;

  typedef struct packed {
    op_e                req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               cmp_true;
    logic               div_error;
  } res_t;
endpackage

### test/rna_checker.sv
// Checker: predicts each result from accepted requests and compares in order.
`timescale 1ns / 1ps
module rna_checker
  import rna_pkg::*;
  import rna_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  res_t        res_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  res_t expected_q[$];
  int unsigned fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Divides n/d by their gcd; returns 0 when the gcd is zero (0/0).
  function automatic bit reduce_frac(inout longint n, inout longint d);
    longint unsigned g;
    g = euclid_gcd(abs64(n), abs64(d));
    if (g == 0) return 1'b0;
    n = wrap32(n / longint'(g));
    d = wrap32(d / longint'(g));
    return 1'b1;
  endfunction

  function automatic res_t predict_rational(req_t q);
    res_t   r;
    logic [3:0] code;
    longint an, ad, bn, bd, rn, rd, xn, xd, yn, yd;
    bit     cmp, err, eq, lt, oka, okb;
    code = q.req_type;
    an = q.a_num; ad = q.a_den; bn = q.b_num; bd = q.b_den;
    rn = 0; rd = 1; cmp = 0; err = 0;
    if (code == OP_SUB) begin
      bn   = wrap32(-bn);
      code = OP_ADD;
    end
    case (code)
      OP_ADD: begin
        if (ad == bd) begin
          rn = wrap32(an + bn);
          rd = ad;
        end else begin
          rn = wrap32(an * bd + bn * ad);
          rd = wrap32(ad * bd);
        end
      end
      OP_MUL: begin
        rn = wrap32(an * bn);
        rd = wrap32(ad * bd);
      end
      OP_DIV: begin
        rn  = wrap32(an * bd);
        rd  = wrap32(ad * bn);
        err = (bn == 0);
      end
      OP_NEG: begin
        rn = wrap32(-an);
        rd = ad;
      end
      OP_RECIP: begin
        rn  = ad;
        rd  = an;
        err = (an == 0);
      end
      OP_REDUCE: begin
        rn  = an;
        rd  = ad;
        err = !reduce_frac(rn, rd);
      end
      OP_WHOLE: begin
        if (ad == 0) err = 1;
        else rn = wrap32(an / ad);
      end
      OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE, OP_NE: begin
        xn = an; xd = ad; yn = bn; yd = bd;
        oka = reduce_frac(xn, xd);
        okb = reduce_frac(yn, yd);
        err = !(oka && okb);
        eq  = (xn == yn) && (xd == yd);
        lt  = (an * bd < bn * ad) && !eq;
        case (code)
          OP_EQ:   cmp = eq;
          OP_LT:   cmp = lt;
          OP_LE:   cmp = lt || eq;
          OP_GT:   cmp = !(lt || eq);
          OP_GE:   cmp = !(lt || eq) || eq;
          default: cmp = !eq;
        endcase
      end
      default: ;
    endcase
    r.res_num   = rn[31:0];
    r.res_den   = rd[31:0];
    r.cmp_true  = cmp;
    r.div_error = err;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Inputs change only at rising edges, so the falling edge sees stable values.
  always @(negedge clk_i) begin
    res_t want;
    if (req_valid_i && req_ready_i) expected_q.push_back(predict_rational(req_data_i));
    if (res_valid_i && res_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result without request", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (res_data_i.res_num !== want.res_num)
          report_mismatch("res_num", res_data_i.res_num, want.res_num);
        if (res_data_i.res_den !== want.res_den)
          report_mismatch("res_den", res_data_i.res_den, want.res_den);
        if (res_data_i.cmp_true !== want.cmp_true)
          report_mismatch("cmp_true", res_data_i.cmp_true, want.cmp_true);
        if (res_data_i.div_error !== want.div_error)
          report_mismatch("div_error", res_data_i.div_error, want.div_error);
      end
    end
  end
endmodule

### test/testbench.sv
// Top of the rational ALU testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;
  import rna_pkg::*;
  import rna_tb_pkg::*;

  localparam int NumRandom = 1800;
  localparam int IdleLimit = 20000;
  localparam int LongStall = 2500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending;
  bit   stim_done = 0;
  bit   long_stall_req = 0;
  int   idle_cycles = 0;

  rna_if #(.payload_t(req_t)) req_ch ();
  rna_if #(.payload_t(res_t)) res_ch ();

  always #2 clk_i = ~clk_i;

  rational_number_alu_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .res   (res_ch.source)
  );

  rna_checker u_checker (
    .clk_i       (clk_i),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .res_valid_i (res_ch.valid),
    .res_ready_i (res_ch.ready),
    .res_data_i  (res_ch.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'd0;
          default: return 32'd1;
        endcase
      end
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t q;
    logic signed [31:0] k;
    q.req_type = op_e'($urandom_range(0, 15));
    q.a_num = pick_value();
    q.a_den = pick_value();
    case ($urandom_range(0, 3))
      0: begin  // scaled copy, so equality holds often
        k = $signed($urandom_range(1, 9)) * ($urandom_range(0, 1) ? 1 : -1);
        q.b_num = q.a_num * k;
        q.b_den = q.a_den * k;
      end
      1: begin
        q.b_num = pick_value();
        q.b_den = q.a_den;
      end
      default: begin
        q.b_num = pick_value();
        q.b_den = pick_value();
      end
    endcase
    return q;
  endfunction

  task automatic send_request(req_t q);
    bit hit;
    req_ch.valid <= 1'b1;
    req_ch.data  <= q;
    do begin
      @(negedge clk_i);
      hit = req_ch.ready;
      @(posedge clk_i);
    end while (!hit);
  endtask

  task automatic send_directed(op_e op, logic [31:0] an, ad, bn, bd);
    req_t q;
    q.req_type = op;
    q.a_num = an; q.a_den = ad; q.b_num = bn; q.b_den = bd;
    send_request(q);
  endtask

  // Sender
  initial begin
    req_t q;
    int   burst;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed(OP_ADD, 1, 3, 1, 3);
    send_directed(OP_ADD, 32'h7fff_ffff, 7, 32'h8000_0000, 5);
    send_directed(OP_SUB, 5, 4, 32'h8000_0000, 4);
    send_directed(OP_SUB, 1, 2, 1, 3);
    send_directed(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, -1, 3);
    send_directed(OP_DIV, 3, 4, 0, 5);
    send_directed(OP_DIV, 3, 4, 5, 6);
    send_directed(OP_NEG, 32'h8000_0000, 1, 0, 0);
    send_directed(OP_RECIP, 0, 9, 0, 0);
    send_directed(OP_RECIP, -4, 9, 0, 0);
    send_directed(OP_REDUCE, 0, 0, 0, 0);
    send_directed(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_directed(OP_REDUCE, -12, 18, 0, 0);
    send_directed(OP_WHOLE, 7, 0, 0, 0);
    send_directed(OP_WHOLE, 32'h8000_0000, -1, 0, 0);
    send_directed(OP_WHOLE, -7, 2, 0, 0);
    send_directed(OP_EQ, 2, 4, -1, -2);
    send_directed(OP_EQ, 1, 2, 2, 4);
    send_directed(OP_LT, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
    send_directed(OP_LE, 0, 0, 1, 2);
    send_directed(OP_GT, 3, 2, 1, 2);
    send_directed(OP_GE, 1, 2, 2, 4);
    send_directed(OP_NE, 1, 2, 1, 3);
    send_directed(op_e'(4'd14), 1, 2, 3, 4);
    send_directed(op_e'(4'd15), 5, 6, 7, 8);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) begin
        if (n == NumRandom / 2) long_stall_req = 1;
        q = random_request();
        send_request(q);
      end
      if ($urandom_range(0, 2) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
    end
    req_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: stall pattern, plus one long hold-off while the sender keeps going
  initial begin
    int mode;
    res_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      for (int c = $urandom_range(10, 300); c > 0; c--) begin
        @(posedge clk_i);
        if (long_stall_req) begin
          long_stall_req = 0;
          res_ch.ready <= 1'b0;
          repeat (LongStall) @(posedge clk_i);
        end
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 3) != 0);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ((c % 7) < 3);
        endcase
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(negedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
